// File: rtl/core/rrg_pkg.sv
// Shared types and constants for the rounded-rectangle gradient shader.
package rrg_pkg;

    localparam int COORD_BITS = 12;
    localparam int COLOR_BITS = 24;
    localparam int CFG_IDX_BITS = 3;
    localparam int T_BITS = 8;
    localparam int CHAN_MAX = 255;
    // Quotient bits of row*255/(h-1), one per divider stage.
    localparam int DIV_STAGES = T_BITS;
    // Pipeline delays from the input register to the mask result and to the blended color.
    localparam int MASK_LAT = 3;
    localparam int COLOR_LAT = 1 + DIV_STAGES + 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WIDTH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_RADIUS = 3'd2,
        CFG_TOP    = 3'd3,
        CFG_BOTTOM = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [COORD_BITS-1:0] col_offset;
        logic [COORD_BITS-1:0] row_offset;
    } t_pix_in;

    typedef struct packed {
        logic                  draw;
        logic [COLOR_BITS-1:0] pixel_color;
    } t_pix_out;

    typedef struct packed {
        logic [COORD_BITS-1:0] width;
        logic [COORD_BITS-1:0] height;
        logic [COORD_BITS-1:0] radius;
        logic [COLOR_BITS-1:0] top;
        logic [COLOR_BITS-1:0] bottom;
    } t_cfg;

endpackage

// File: rtl/core/rounded_rect_gradient_shader.sv
// Top level of the rounded-rectangle vertical-gradient pixel shader.
// One pixel is accepted every clock (o_busy stays low); its result appears on o_pix with
// o_valid in input order. The color path runs through the input register, the divider setup
// stage, the eight-stage gradient divider, the three-stage color blend and the output register.
// Results cannot be held off. Configuration must be written through i_cfg_* only while no
// pixels are in flight; the block itself does not enforce it.
module rounded_rect_gradient_shader (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  rrg_pkg::t_pix_in                 i_pix,
    output logic                             o_valid,
    output rrg_pkg::t_pix_out                o_pix,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rrg_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [rrg_pkg::COLOR_BITS-1:0]   i_cfg_data
);
    import rrg_pkg::*;

    localparam int DLY = COLOR_LAT - MASK_LAT;

    t_cfg                  cfg;
    logic [COORD_BITS-1:0] r_col, r_row;
    logic [COLOR_LAT:0]    r_vld;
    logic                  mask_draw, mask_out;
    logic [DLY-1:0]        r_draw_dly, r_out_dly;
    logic [T_BITS-1:0]     t;
    logic [COLOR_BITS-1:0] color;
    t_pix_out              r_pix;
    logic                  r_valid;

    assign o_busy = 1'b0;

    rrg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    always_ff @(posedge i_clk) begin
        r_col <= i_pix.col_offset;
        r_row <= i_pix.row_offset;
        r_draw_dly <= {r_draw_dly[DLY-2:0], mask_draw};
        r_out_dly  <= {r_out_dly[DLY-2:0], mask_out};
        r_pix.draw <= r_draw_dly[DLY-1] && !r_out_dly[DLY-1];
        r_pix.pixel_color <= r_out_dly[DLY-1] ? '0 : color;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_vld   <= {r_vld[COLOR_LAT-1:0], i_start && !o_busy};
            r_valid <= r_vld[COLOR_LAT];
        end
    end

    rrg_mask u_mask (
        .i_clk     (i_clk),
        .i_col     (r_col),
        .i_row     (r_row),
        .i_cfg     (cfg),
        .o_draw    (mask_draw),
        .o_outside (mask_out)
    );

    rrg_div u_div (
        .i_clk    (i_clk),
        .i_row    (r_row),
        .i_height (cfg.height),
        .o_t      (t)
    );

    rrg_blend u_blend (
        .i_clk    (i_clk),
        .i_t      (t),
        .i_top    (cfg.top),
        .i_bottom (cfg.bottom),
        .o_color  (color)
    );

    assign o_valid = r_valid;
    assign o_pix   = r_pix;

endmodule

// File: rtl/core/rrg_cfg.sv
// Configuration registers with the corner radius clamp.
module rrg_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rrg_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [rrg_pkg::COLOR_BITS-1:0] i_cfg_data,
    output rrg_pkg::t_cfg                  o_cfg
);
    import rrg_pkg::*;

    logic [COORD_BITS-1:0] r_width, r_height, r_radius;
    logic [COLOR_BITS-1:0] r_top, r_bottom;
    logic [COORD_BITS:0]   rad_w, rad_h;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= '0;
            r_height <= '0;
            r_radius <= '0;
            r_top    <= '0;
            r_bottom <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH:  r_width  <= i_cfg_data[COORD_BITS-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[COORD_BITS-1:0];
                CFG_RADIUS: r_radius <= i_cfg_data[COORD_BITS-1:0];
                CFG_TOP:    r_top    <= i_cfg_data;
                CFG_BOTTOM: r_bottom <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp to half the width, then half the height.
    always_comb begin
        rad_w = {1'b0, r_radius};
        if ({rad_w[COORD_BITS-1:0], 1'b0} > {1'b0, r_width} || rad_w[COORD_BITS-1])
            rad_w = {2'b0, r_width[COORD_BITS-1:1]};
        rad_h = rad_w;
        if ({rad_h[COORD_BITS-1:0], 1'b0} > {1'b0, r_height} || rad_h[COORD_BITS-1])
            rad_h = {2'b0, r_height[COORD_BITS-1:1]};
    end

    assign o_cfg.width  = r_width;
    assign o_cfg.height = r_height;
    assign o_cfg.radius = rad_h[COORD_BITS-1:0];
    assign o_cfg.top    = r_top;
    assign o_cfg.bottom = r_bottom;

endmodule

// File: rtl/core/rrg_mask.sv
// Rectangle bounds and rounded-corner distance test, three stages.
module rrg_mask (
    input  logic                         i_clk,
    input  logic [rrg_pkg::COORD_BITS-1:0] i_col,
    input  logic [rrg_pkg::COORD_BITS-1:0] i_row,
    input  rrg_pkg::t_cfg                i_cfg,
    output logic                         o_draw,
    output logic                         o_outside
);
    import rrg_pkg::*;

    logic [COORD_BITS-1:0]   r1_dx, r1_dy, r1_r;
    logic                    r1_corner, r1_out;
    logic [2*COORD_BITS-1:0] r2_dx2, r2_dy2, r2_r2;
    logic                    r2_corner, r2_out;
    logic                    r3_draw, r3_out;

    logic                    left, right, upper, lower;
    logic [COORD_BITS:0]     n_dx, n_dy;
    logic [2*COORD_BITS:0]   sum;

    always_comb begin
        left  = i_col < i_cfg.radius;
        right = i_col >= i_cfg.width - i_cfg.radius;
        upper = i_row < i_cfg.radius;
        lower = i_row >= i_cfg.height - i_cfg.radius;
        if (left)
            n_dx = {1'b0, i_cfg.radius} - {1'b0, i_col};
        else
            n_dx = {1'b0, i_col} - {1'b0, i_cfg.width} + {1'b0, i_cfg.radius} + 1'b1;
        if (upper)
            n_dy = {1'b0, i_cfg.radius} - {1'b0, i_row};
        else
            n_dy = {1'b0, i_row} - {1'b0, i_cfg.height} + {1'b0, i_cfg.radius} + 1'b1;
    end

    assign sum = {1'b0, r2_dx2} + {1'b0, r2_dy2};

    always_ff @(posedge i_clk) begin
        r1_dx     <= n_dx[COORD_BITS-1:0];
        r1_dy     <= n_dy[COORD_BITS-1:0];
        r1_r      <= i_cfg.radius;
        r1_corner <= (left || right) && (upper || lower);
        r1_out    <= (i_col >= i_cfg.width) || (i_row >= i_cfg.height);

        r2_dx2    <= r1_dx * r1_dx;
        r2_dy2    <= r1_dy * r1_dy;
        r2_r2     <= r1_r * r1_r;
        r2_corner <= r1_corner;
        r2_out    <= r1_out;

        r3_draw   <= !(r2_corner && (sum > {1'b0, r2_r2}));
        r3_out    <= r2_out;
    end

    assign o_draw    = r3_draw;
    assign o_outside = r3_out;

endmodule

// File: rtl/core/rrg_div.sv
// Gradient weight row*255/(h-1): one restoring quotient bit per stage.
module rrg_div (
    input  logic                         i_clk,
    input  logic [rrg_pkg::COORD_BITS-1:0] i_row,
    input  logic [rrg_pkg::COORD_BITS-1:0] i_height,
    output logic [rrg_pkg::T_BITS-1:0]   o_t
);
    import rrg_pkg::*;

    localparam int NW = COORD_BITS + T_BITS;

    logic [NW-1:0]         r_rem [0:DIV_STAGES];
    logic [COORD_BITS-1:0] r_d   [0:DIV_STAGES];
    logic [T_BITS-1:0]     r_q   [0:DIV_STAGES];
    logic                  r_z   [0:DIV_STAGES];

    always_ff @(posedge i_clk) begin
        r_rem[0] <= {i_row, {T_BITS{1'b0}}} - {{T_BITS{1'b0}}, i_row};
        r_d[0]   <= i_height - 1'b1;
        r_q[0]   <= '0;
        r_z[0]   <= i_height <= COORD_BITS'(1);
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        localparam int SH = DIV_STAGES - 1 - k;
        logic [NW-1:0] dsh;
        assign dsh = NW'(r_d[k]) << SH;
        always_ff @(posedge i_clk) begin
            r_d[k+1] <= r_d[k];
            r_z[k+1] <= r_z[k];
            if (r_rem[k] >= dsh) begin
                r_rem[k+1] <= r_rem[k] - dsh;
                r_q[k+1]   <= r_q[k] | (T_BITS'(1) << SH);
            end else begin
                r_rem[k+1] <= r_rem[k];
                r_q[k+1]   <= r_q[k];
            end
        end
    end

    assign o_t = r_z[DIV_STAGES] ? '0 : r_q[DIV_STAGES];

endmodule

// File: rtl/core/rrg_blend.sv
// Per-channel blend a+(b-a)*t/255, truncated toward zero, three stages.
module rrg_blend (
    input  logic                         i_clk,
    input  logic [rrg_pkg::T_BITS-1:0]   i_t,
    input  logic [rrg_pkg::COLOR_BITS-1:0] i_top,
    input  logic [rrg_pkg::COLOR_BITS-1:0] i_bottom,
    output logic [rrg_pkg::COLOR_BITS-1:0] o_color
);
    import rrg_pkg::*;

    localparam int NCH = COLOR_BITS / T_BITS;

    for (genvar c = 0; c < NCH; c++) begin : g_ch
        logic [T_BITS-1:0]   a, b, mag;
        logic                neg;
        logic [2*T_BITS-1:0] r1_prod;
        logic                r1_neg, r2_neg;
        logic [T_BITS-1:0]   r1_a, r2_a, r2_q, r3_ch;
        logic [2*T_BITS:0]   qsum;

        assign a   = i_top[c*T_BITS +: T_BITS];
        assign b   = i_bottom[c*T_BITS +: T_BITS];
        assign neg = b < a;
        assign mag = neg ? a - b : b - a;
        // x/255 for x up to 255*255
        assign qsum = {1'b0, r1_prod} + (2*T_BITS+1)'(r1_prod >> T_BITS) + 1'b1;

        always_ff @(posedge i_clk) begin
            r1_prod <= mag * i_t;
            r1_neg  <= neg;
            r1_a    <= a;
            r2_q    <= qsum[2*T_BITS-1:T_BITS];
            r2_neg  <= r1_neg;
            r2_a    <= r1_a;
            r3_ch   <= r2_neg ? r2_a - r2_q : r2_a + r2_q;
        end

        assign o_color[c*T_BITS +: T_BITS] = r3_ch;
    end

endmodule
